// ===== rtl/aair_pkg.sv =====
// shared types, constants and helpers for the area average resampler
`default_nettype none

package aair_pkg;

    localparam int MAX_SIZE    = 96;
    localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int SIZE_W      = 7;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 8;
    localparam int SUM_W       = $clog2(STORE_DEPTH * 255 + 1);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(SUM_W);

    localparam logic [0:0] REG_SOURCE_SIZE = 1'b0;
    localparam logic [0:0] REG_TARGET_SIZE = 1'b1;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  source_index;
        logic [PIX_W-1:0]  source_value;
        logic [SIZE_W-1:0] out_x;
        logic [SIZE_W-1:0] out_y;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [IDX_W-1:0] out_address;
        logic             status;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DSTART,
        ST_DWAIT,
        ST_CLIP,
        ST_SCAN,
        ST_DRAIN,
        ST_ASTART,
        ST_AWAIT,
        ST_OUT
    } t_state;

    // size register value in use, held to 1..MAX_SIZE
    function automatic logic [SIZE_W-1:0] size_in_use(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_SIZE)) begin
            r = SIZE_W'(MAX_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/area_average_image_resampler.sv =====
// top level: sequencer around a shared divider and the source pixel store
// a write beat is taken in IDLE; the block is ready again on the next cycle
// a compute beat runs four divider passes for the box edges, a clip step, a scan of the box
//   pixels, a drain step, one divider pass for the average and an output step
// an out of range coordinate skips the divider and goes straight to the output step
// synchronous active-low reset clears control state, sets sizes to 96; memory is not cleared
`default_nettype none

module area_average_image_resampler import aair_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_beat          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_beat              o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [SIZE_W-1:0] i_cfg_data
);

    localparam int MUL_W = 2 * SIZE_W + 1;

    t_state r_state, n_state;

    // configuration
    logic [SIZE_W-1:0] r_src_size, r_tgt_size;

    // per request working registers
    logic [SIZE_W-1:0] r_x, n_x, r_y, n_y, r_w, n_w, r_p, n_p;
    logic [1:0]        r_phase, n_phase;
    logic [SIZE_W-1:0] r_left, n_left, r_right, n_right;
    logic [SIZE_W-1:0] r_top, n_top, r_bottom, n_bottom;
    logic [SIZE_W-1:0] r_xx, n_xx, r_yy, n_yy;
    logic [IDX_W-1:0]  r_row_base, n_row_base;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_pend, n_pend;
    t_out_beat         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    // shared divider hookup
    logic              div_start;
    logic [SUM_W-1:0]  div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic              div_done;
    logic [SUM_W-1:0]  div_quotient;

    // store hookup
    logic              st_we;
    logic [IDX_W-1:0]  st_raddr;
    logic [PIX_W-1:0]  st_rdata;

    // helpers
    logic                in_acc;
    logic [SIZE_W:0]     mul_a;
    logic [MUL_W-1:0]    mul_prod;
    logic [SIZE_W-1:0]   x_in_use_w, p_in_use;
    logic [SIZE_W:0]     left_plus, top_plus;
    logic [SIZE_W-1:0]   right_lo, bottom_lo;
    logic [SIZE_W:0]     stride_sum;
    logic [SIZE_W-1:0]   stride;
    logic [2*SIZE_W-1:0] addr_prod;
    logic [2*SIZE_W:0]   addr_sum;
    logic                last_col, last_row;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign x_in_use_w = size_in_use(r_src_size);
    assign p_in_use   = size_in_use(r_tgt_size);

    // box edge products: x*w, (x+1)*w, y*w, (y+1)*w by phase
    assign mul_a    = (r_phase[1] ? {1'b0, r_y} : {1'b0, r_x}) + {{SIZE_W{1'b0}}, r_phase[0]};
    assign mul_prod = {{(MUL_W-SIZE_W-1){1'b0}}, mul_a} * {{(MUL_W-SIZE_W){1'b0}}, r_w};

    // widen the box to at least one pixel, then clip to the source
    assign left_plus = {1'b0, r_left} + (SIZE_W+1)'(1);
    assign top_plus  = {1'b0, r_top} + (SIZE_W+1)'(1);
    assign right_lo  = ({1'b0, r_right} < left_plus) ? left_plus[SIZE_W-1:0] : r_right;
    assign bottom_lo = ({1'b0, r_bottom} < top_plus) ? top_plus[SIZE_W-1:0] : r_bottom;

    // padded stride, target size rounded up to a multiple of 4
    assign stride_sum = ({1'b0, r_p} + (SIZE_W+1)'(3)) & ~(SIZE_W+1)'(3);
    assign stride     = stride_sum[SIZE_W-1:0];
    assign addr_prod  = {{SIZE_W{1'b0}}, r_y} * {{SIZE_W{1'b0}}, stride};
    assign addr_sum   = {1'b0, addr_prod} + {{(SIZE_W+1){1'b0}}, r_x};

    assign last_col = ({1'b0, r_xx} + (SIZE_W+1)'(1)) == {1'b0, r_right};
    assign last_row = ({1'b0, r_yy} + (SIZE_W+1)'(1)) == {1'b0, r_bottom};

    assign st_we    = in_acc && (i_in_data.req_type == REQ_WRITE)
                      && (i_in_data.source_index < IDX_W'(STORE_DEPTH));
    assign st_raddr = r_row_base + {{(IDX_W-SIZE_W){1'b0}}, r_xx};

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_p         = r_p;
        n_phase     = r_phase;
        n_left      = r_left;
        n_right     = r_right;
        n_top       = r_top;
        n_bottom    = r_bottom;
        n_xx        = r_xx;
        n_yy        = r_yy;
        n_row_base  = r_row_base;
        n_addr      = r_addr;
        n_sum       = r_sum;
        n_count     = r_count;
        n_pend      = 1'b0;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        div_start    = 1'b0;
        div_dividend = {{(SUM_W-MUL_W){1'b0}}, mul_prod};
        div_divisor  = {{(CNT_W-SIZE_W){1'b0}}, r_p};

        // accumulate the pixel read in the previous cycle
        if (r_pend) begin
            n_sum   = r_sum + {{(SUM_W-PIX_W){1'b0}}, st_rdata};
            n_count = r_count + CNT_W'(1);
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.req_type == REQ_COMPUTE)) begin
                    n_x     = i_in_data.out_x;
                    n_y     = i_in_data.out_y;
                    n_w     = x_in_use_w;
                    n_p     = p_in_use;
                    n_phase = 2'd0;
                    if ((i_in_data.out_x >= p_in_use) || (i_in_data.out_y >= p_in_use)) begin
                        n_res   = '{pixel_value: '0, out_address: '0, status: STATUS_RANGE};
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_DSTART;
                    end
                end
            end
            ST_DSTART: begin
                div_start = 1'b1;
                n_state   = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    case (r_phase)
                        2'd0:    n_left   = div_quotient[SIZE_W-1:0];
                        2'd1:    n_right  = div_quotient[SIZE_W-1:0];
                        2'd2:    n_top    = div_quotient[SIZE_W-1:0];
                        default: n_bottom = div_quotient[SIZE_W-1:0];
                    endcase
                    n_phase = r_phase + 2'd1;
                    n_state = (r_phase == 2'd3) ? ST_CLIP : ST_DSTART;
                end
            end
            ST_CLIP: begin
                n_right    = (right_lo > r_w) ? r_w : right_lo;
                n_bottom   = (bottom_lo > r_w) ? r_w : bottom_lo;
                n_xx       = r_left;
                n_yy       = r_top;
                n_row_base = {{(IDX_W-SIZE_W){1'b0}}, r_top} * {{(IDX_W-SIZE_W){1'b0}}, r_w};
                n_addr     = addr_sum[IDX_W-1:0];
                n_sum      = '0;
                n_count    = '0;
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                // one store read per cycle, row by row
                n_pend = 1'b1;
                if (last_col) begin
                    n_xx       = r_left;
                    n_yy       = r_yy + SIZE_W'(1);
                    n_row_base = r_row_base + {{(IDX_W-SIZE_W){1'b0}}, r_w};
                    if (last_row) begin
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_xx = r_xx + SIZE_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_ASTART;
            end
            ST_ASTART: begin
                div_start    = 1'b1;
                div_dividend = r_sum;
                div_divisor  = r_count;
                n_state      = ST_AWAIT;
            end
            ST_AWAIT: begin
                div_divisor = r_count;
                if (div_done) begin
                    n_res   = '{pixel_value: div_quotient[PIX_W-1:0],
                                out_address: r_addr, status: STATUS_OK};
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // hand over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_src_size  <= SIZE_W'(MAX_SIZE);
            r_tgt_size  <= SIZE_W'(MAX_SIZE);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            if (i_cfg_we && (i_cfg_index == REG_SOURCE_SIZE)) begin
                r_src_size <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == REG_TARGET_SIZE)) begin
                r_tgt_size <= i_cfg_data;
            end
        end
        r_x        <= n_x;
        r_y        <= n_y;
        r_w        <= n_w;
        r_p        <= n_p;
        r_phase    <= n_phase;
        r_left     <= n_left;
        r_right    <= n_right;
        r_top      <= n_top;
        r_bottom   <= n_bottom;
        r_xx       <= n_xx;
        r_yy       <= n_yy;
        r_row_base <= n_row_base;
        r_addr     <= n_addr;
        r_sum      <= n_sum;
        r_count    <= n_count;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    aair_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    aair_store u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (i_in_data.source_index),
        .i_wdata (i_in_data.source_value),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/aair_divider.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module aair_divider import aair_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [SUM_W-1:0]      o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [SUM_W-1:0]     r_quo, n_quo;
    logic [CNT_W-1:0]     r_dvs, n_dvs;
    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       diff;

    always_comb begin
        shifted = {r_rem, r_quo[SUM_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = diff[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/aair_store.sv =====
// source pixel memory, one write port and one registered read port
`default_nettype none

module aair_store import aair_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire logic [PIX_W-1:0] i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output logic [PIX_W-1:0]      o_rdata
);

    logic [PIX_W-1:0] r_mem [STORE_DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/aair_checker.sv =====
// port level checks for the resampler and their bind
`default_nettype none

module aair_checker import aair_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire t_in_beat          i_in_data,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire t_out_beat         o_out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // a range error carries zero pixel and zero address
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == STATUS_RANGE)
        |-> (o_out_data.pixel_value == '0) && (o_out_data.out_address == '0))
        else $error("range error with nonzero payload");

    // a write beat leaves the block ready on the next cycle
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.req_type == REQ_WRITE) |=> !o_in_stall)
        else $error("busy after a write beat");

    // a compute beat makes the block busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.req_type == REQ_COMPUTE) |=> o_in_stall)
        else $error("ready right after a compute beat");

endmodule

bind area_average_image_resampler aair_checker u_aair_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== tb/tb_area_average_image_resampler.sv =====
// self-checking testbench for the area average image resampler
`default_nettype none

module tb_area_average_image_resampler;
    import aair_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE      = 4;      // a write beat lands in the store at the edge that takes it
    localparam int TAIL_WAIT   = 200;    // longer than one compute with a small box
    localparam int ITEM_GOAL   = 750;
    localparam int TAIL_ITEMS  = 60;
    localparam int REPORT_MAX  = 10;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // block inputs, all known from time zero
    logic              i_in_valid  = 1'b0;
    t_in_beat          i_in_data   = '0;
    logic              i_out_stall = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [0:0]        i_cfg_index = '0;
    logic [SIZE_W-1:0] i_cfg_data  = '0;

    // block outputs
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;

    area_average_image_resampler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state: own copy of the size registers and the pixel store
    logic [SIZE_W-1:0] src_size_reg = SIZE_W'(96);
    logic [SIZE_W-1:0] tgt_size_reg = SIZE_W'(96);
    logic [PIX_W-1:0]  src_store   [STORE_DEPTH];
    bit                src_written [STORE_DEPTH];

    // averages still owed by the block, oldest first
    t_out_beat pending_pixels[$];

    // bookkeeping
    int  error_count  = 0;
    int  cycle_count  = 0;
    int  n_items      = 0;
    int  n_writes     = 0;
    int  n_dropped    = 0;
    int  n_computes   = 0;
    int  n_range      = 0;
    int  n_cfg_writes = 0;
    bit  idle_on      = 1'b0;  // random gaps and stalls on both sides

    // size register as the block uses it: 0 acts as 1, above the max acts as the max
    function automatic int active_size(input logic [SIZE_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_SIZE) return MAX_SIZE;
        return int'(v);
    endfunction

    // expected result of one compute beat against the current store and sizes
    function automatic t_out_beat average_box(input logic [SIZE_W-1:0] ox,
                                              input logic [SIZE_W-1:0] oy);
        t_out_beat res;
        int w, p, xi, yi, lft, rgt, top, bot, sum, cnt, stride, addr;
        res = '0;
        w   = active_size(src_size_reg);
        p   = active_size(tgt_size_reg);
        xi  = int'(ox);
        yi  = int'(oy);
        if (xi >= p || yi >= p) begin
            // coordinate outside the target: zero pixel, zero address
            res.status = STATUS_RANGE;
            return res;
        end
        lft = xi * w / p;
        rgt = (xi + 1) * w / p;
        if (rgt < lft + 1) rgt = lft + 1;
        if (rgt > w) rgt = w;
        top = yi * w / p;
        bot = (yi + 1) * w / p;
        if (bot < top + 1) bot = top + 1;
        if (bot > w) bot = w;
        sum = 0;
        cnt = 0;
        for (int yy = top; yy < bot; yy++) begin
            for (int xx = lft; xx < rgt; xx++) begin
                addr = yy * w + xx;
                if (addr < STORE_DEPTH) sum += int'(src_store[addr]);
                cnt++;
            end
        end
        if (cnt < 1) cnt = 1;
        // output rows are padded to a multiple of four
        stride          = (p + 3) & ~3;
        res.pixel_value = PIX_W'(sum / cnt);
        res.out_address = IDX_W'(yi * stride + xi);
        res.status      = STATUS_OK;
        return res;
    endfunction

    // a pixel write beat; the compute fields carry noise
    function automatic t_in_beat write_beat(input int idx, input int val);
        t_in_beat b;
        b.req_type     = REQ_WRITE;
        b.source_index = IDX_W'(idx);
        b.source_value = PIX_W'(val);
        b.out_x        = SIZE_W'($urandom);
        b.out_y        = SIZE_W'($urandom);
        return b;
    endfunction

    // a compute beat; the write fields carry noise
    function automatic t_in_beat compute_beat(input int ox, input int oy);
        t_in_beat b;
        b.req_type     = REQ_COMPUTE;
        b.source_index = IDX_W'($urandom);
        b.source_value = PIX_W'($urandom);
        b.out_x        = SIZE_W'(ox);
        b.out_y        = SIZE_W'(oy);
        return b;
    endfunction

    task automatic log_error(input string msg);
        if (error_count < REPORT_MAX) $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // present one beat, hold it until it is taken, then update the predictor;
    // valid stays high so a following beat can go out on the next edge
    task automatic send_beat(input t_in_beat b);
        t_out_beat want;
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        n_items++;
        if (b.req_type == REQ_WRITE) begin
            if (int'(b.source_index) < STORE_DEPTH) begin
                src_store[b.source_index]   = b.source_value;
                src_written[b.source_index] = 1'b1;
                n_writes++;
            end else begin
                n_dropped++;
            end
        end else begin
            want = average_box(b.out_x, b.out_y);
            pending_pixels.push_back(want);
            n_computes++;
            if (want.status == STATUS_RANGE) n_range++;
        end
    endtask

    // lower valid; always waits for the next clock edge so valid is never driven twice in a step
    task automatic sender_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results();
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // write one size register while the block is idle
    task automatic write_size(input logic [0:0] idx, input int val);
        sender_idle();
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= SIZE_W'(val);
        @(posedge i_clk);
        if (idx == REG_SOURCE_SIZE) src_size_reg = SIZE_W'(val);
        else tgt_size_reg = SIZE_W'(val);
        n_cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // write every pixel of the box for (ox, oy) that was never written
    task automatic cover_box(input int ox, input int oy);
        int w, p, lft, rgt, top, bot, addr;
        w = active_size(src_size_reg);
        p = active_size(tgt_size_reg);
        if (ox >= p || oy >= p) return;
        lft = ox * w / p;
        rgt = (ox + 1) * w / p;
        if (rgt < lft + 1) rgt = lft + 1;
        if (rgt > w) rgt = w;
        top = oy * w / p;
        bot = (oy + 1) * w / p;
        if (bot < top + 1) bot = top + 1;
        if (bot > w) bot = w;
        for (int yy = top; yy < bot; yy++) begin
            for (int xx = lft; xx < rgt; xx++) begin
                addr = yy * w + xx;
                if (!src_written[addr]) send_beat(write_beat(addr, $urandom_range(0, 255)));
            end
        end
    endtask

    // a compute beat whose box is known to the predictor
    task automatic send_compute(input int ox, input int oy);
        cover_box(ox, oy);
        send_beat(compute_beat(ox, oy));
    endtask

    task automatic set_sizes(input int src, input int tgt);
        write_size(REG_SOURCE_SIZE, src);
        write_size(REG_TARGET_SIZE, tgt);
    endtask

    // mostly in-range computes and rewrites of the live area, some noise
    task automatic send_random_item();
        int w, p, pick;
        w    = active_size(src_size_reg);
        p    = active_size(tgt_size_reg);
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            send_compute($urandom_range(0, p - 1), $urandom_range(0, p - 1));
        end else if (pick < 72) begin
            send_compute($urandom_range(0, 127), $urandom_range(0, 127));
        end else if (pick < 88) begin
            send_beat(write_beat($urandom_range(0, w * w - 1), $urandom_range(0, 255)));
        end else if (pick < 95) begin
            send_beat(write_beat($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 255)));
        end else begin
            // address past the store: dropped by the block
            send_beat(write_beat($urandom_range(STORE_DEPTH, 16383), $urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------- tests

    // reset sizes, store address extremes, dropped writes, range errors
    task automatic test_store_extremes();
        idle_on = 1'b1;
        send_beat(write_beat(0, 8'hFF));
        send_beat(write_beat(STORE_DEPTH - 1, 8'h00));
        send_beat(write_beat(8191, 8'hAA));
        send_beat(write_beat(8192, 8'h55));
        send_compute(0, 0);
        // writes past the store must not land on a low address
        send_beat(write_beat(STORE_DEPTH, 8'h00));
        send_beat(write_beat(16383, 8'h00));
        send_compute(0, 0);
        send_compute(95, 95);
        send_compute(64, 64);
        send_compute(95, 0);
        send_compute(96, 5);
        send_compute(5, 96);
        send_compute(127, 127);
    endtask

    // saturation of the size registers, whole-image box, odd strides, upscale
    task automatic test_size_limits();
        set_sizes(0, 127);        // 1 pixel source onto 96x96
        send_compute(0, 0);
        send_compute(95, 95);
        send_compute(96, 0);
        set_sizes(127, 127);      // both held at the max
        send_compute(0, 0);
        send_compute(95, 95);
        send_compute(96, 0);
        set_sizes(12, 0);         // whole 12x12 source onto one pixel
        send_compute(0, 0);
        send_compute(1, 0);
        send_compute(0, 1);
        set_sizes(1, 1);
        send_compute(0, 0);
        set_sizes(20, 5);         // stride pads 5 up to 8
        send_compute(4, 4);
        send_compute(0, 3);
        set_sizes(5, 96);
        send_compute(95, 95);
        send_compute(17, 80);
        set_sizes(7, 3);          // stride pads 3 up to 4
        send_compute(2, 2);
        send_compute(3, 0);
    endtask

    // sender holds off until the block has returned everything
    task automatic test_sender_pause();
        set_sizes(12, 4);
        idle_on = 1'b1;
        repeat (10) send_random_item();
        sender_idle();
        wait_results();
        repeat (10) send_random_item();
    endtask

    // random segments, each with its own sizes
    task automatic test_random_mix();
        int kind, seg_len;
        while (n_items < ITEM_GOAL - TAIL_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // large source, ratio at most about two
                set_sizes($urandom_range(64, 127), $urandom_range(48, 127));
            end else if (kind == 1) begin
                // tiny source, heavy upscale
                set_sizes($urandom_range(0, 4), $urandom_range(0, 127));
            end else begin
                set_sizes($urandom_range(1, 16), $urandom_range(1, 16));
            end
            idle_on = ($urandom_range(0, 3) != 0);
            seg_len = $urandom_range(10, 40);
            repeat (seg_len) send_random_item();
        end
    endtask

    // last stretch with no gaps and no stalls
    task automatic test_quiet_tail();
        set_sizes($urandom_range(2, 12), $urandom_range(2, 12));
        idle_on = 1'b0;
        repeat (TAIL_ITEMS) send_random_item();
    endtask

    // ------------------------------------------------------------ processes

    // receiver stall bursts, started at random while idle_on is set
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker: every accepted beat against the oldest owed average
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                log_error($sformatf("unexpected result pix=%0d addr=%0d st=%0d",
                                    o_out_data.pixel_value, o_out_data.out_address,
                                    o_out_data.status));
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_data.pixel_value !== want.pixel_value ||
                    o_out_data.out_address !== want.out_address ||
                    o_out_data.status !== want.status) begin
                    log_error($sformatf("exp pix=%0d addr=%0d st=%0d got pix=%0d addr=%0d st=%0d",
                                        want.pixel_value, want.out_address, want.status,
                                        o_out_data.pixel_value, o_out_data.out_address,
                                        o_out_data.status));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_area_average_image_resampler: errors");
            $finish;
        end
    end

    // sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_store_extremes();
        test_size_limits();
        test_sender_pause();
        test_random_mix();
        test_quiet_tail();

        sender_idle();
        wait_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            log_error($sformatf("%0d results never arrived", pending_pixels.size()));
        end

        $display("covered %0d beats: %0d pixel writes (%0d dropped past the store), %0d computes",
                 n_items, n_writes, n_dropped, n_computes);
        $display("of which %0d out of range, over %0d size writes, %0d mismatches",
                 n_range, n_cfg_writes, error_count);
        if (error_count == 0) begin
            $display("tb_area_average_image_resampler: clean");
        end else begin
            $display("tb_area_average_image_resampler: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/aair_pkg.sv
rtl/aair_divider.sv
rtl/aair_store.sv
rtl/area_average_image_resampler.sv
rtl/aair_checker.sv
tb/tb_area_average_image_resampler.sv
